// ----- design/sida_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_pkg
// shared types and constants for the integer to decimal ascii converter
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int NumDigits = 10;
    localparam int MaxChars  = NumDigits + 1;
    localparam int NdWidth   = $clog2(NumDigits + 1);

    localparam logic [6:0]  CharZero  = 7'd48;
    localparam logic [6:0]  CharMinus = 7'd45;
    localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
    localparam int          RecipShift = 35;

    typedef logic [3:0] t_digit;

    // payload carried down the digit pipeline
    typedef struct packed {
        logic [31:0]                 mag;     // remaining magnitude
        t_digit [NumDigits-1:0]      digits;  // least significant ends at index 0
        logic [NdWidth-1:0]          nd;      // significant digit count so far
        logic                        neg;
    } t_conv;

endpackage
`default_nettype wire

// ----- design/signed_int_to_decimal_ascii_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// path: an accepted input passes the input register, ten digit stages and the serializer before its first character
// throughput: one character per cycle while i_ready is high; a number of n characters (1..11) holds the
//   output until its last character is taken, set by the character serializer
// the input register plus ten digit stages hold up to eleven numbers in flight
// reset: synchronous active low, clears all valid bits and the serializer
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts a signed 32-bit integer into its decimal ascii text, one character
// per output transaction, most significant first, last character flagged
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_ascii_char,
    output logic             o_last
);
    import sida_pkg::*;

    // input register: sign split and magnitude formed in 32-bit unsigned math,
    // so the most negative value gives magnitude 2^31
    logic   r_in_valid;
    t_conv  r_in;
    t_conv  n_in;
    logic   in_ready;

    // digit pipeline wiring, entry 0 is the input register
    logic  [NumDigits:0] stg_valid;
    logic  [NumDigits:0] stg_ready;
    t_conv [NumDigits:0] stg_data;

    // character serializer
    logic                 r_busy;
    logic                 r_sign;
    logic [3:0]           r_pos;
    t_digit [NumDigits-1:0] r_digits;
    logic                 ser_free;
    logic                 ser_load;
    t_digit               cur_digit;

    always_comb begin
        n_in        = '0;
        n_in.neg    = i_value[31];
        n_in.mag    = i_value[31] ? (32'd0 - i_value) : i_value;
    end

    assign in_ready = !r_in_valid || stg_ready[0];
    assign o_ready  = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in <= n_in;
        end
    end

    assign stg_valid[0] = r_in_valid;
    assign stg_data[0]  = r_in;

    // ten stages, one decimal digit split off in each
    for (genvar k = 0; k < NumDigits; k++) begin : g_stage
        sida_digit_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_data  (stg_data[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_data  (stg_data[k+1])
        );
    end

    // serializer takes the next number once its final character is taken
    assign ser_free             = !r_busy || (i_ready && o_last);
    assign stg_ready[NumDigits] = ser_free;
    assign ser_load             = ser_free && stg_valid[NumDigits];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_pos  <= '0;
        end else if (ser_load) begin
            r_busy <= 1'b1;
            r_sign <= stg_data[NumDigits].neg;
            // zero still yields a single digit
            r_pos  <= (stg_data[NumDigits].nd == '0) ? 4'd0
                                                     : 4'(stg_data[NumDigits].nd - 1'b1);
        end else if (r_busy && i_ready) begin
            priority if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_pos == 4'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= r_pos - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_digits <= stg_data[NumDigits].digits;
        end
    end

    assign cur_digit    = r_digits[r_pos];
    assign o_valid      = r_busy;
    assign o_ascii_char = r_sign ? CharMinus : (CharZero + {3'b000, cur_digit});
    assign o_last       = !r_sign && (r_pos == 4'd0);

    // only the minus sign or a decimal digit goes out
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char == CharMinus
                     || (o_ascii_char >= CharZero && o_ascii_char <= CharZero + 7'd9)))
        else $error("character outside the decimal text set");

    // a minus sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ascii_char == CharMinus) |-> !o_last)
        else $error("minus sign flagged as last");

    // a number never breaks off before its last character
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> o_valid)
        else $error("serializer dropped the rest of a number");

    // digit index stays inside the ten digit slots
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < 4'(NumDigits)))
        else $error("serializer digit index out of range");

endmodule
`default_nettype wire

// ----- design/sida_digit_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_digit_stage
// one pipeline stage: splits off the low decimal digit of the magnitude
// ----------------------------------------------------------------------------
module sida_digit_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire sida_pkg::t_conv i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output sida_pkg::t_conv     o_data
);
    import sida_pkg::*;

    logic         r_valid;
    t_conv        r_data;
    t_conv        n_data;
    logic [63:0]  prod;
    logic [28:0]  quot;
    logic [31:0]  quot_x10;
    logic [31:0]  rem;

    // divide by ten through the reciprocal
    always_comb begin
        prod     = 64'(i_data.mag) * 64'(Recip10);
        quot     = prod[63:RecipShift];
        quot_x10 = {quot, 3'b000} + 32'({quot, 1'b0});
        rem      = i_data.mag - quot_x10;

        n_data                        = i_data;
        n_data.mag                    = 32'(quot);
        n_data.digits[NumDigits-2:0]  = i_data.digits[NumDigits-1:1];
        n_data.digits[NumDigits-1]    = rem[3:0];
        n_data.nd                     = (i_data.mag != 32'd0) ? i_data.nd + 1'b1 : i_data.nd;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // the freshly split digit is always a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.digits[NumDigits-1] <= 4'd9))
        else $error("digit stage produced a digit above nine");

endmodule
`default_nettype wire
